FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfa assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SFA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfa assertion failed");

`endif

FILE: rtl/sfa_pkg.sv
// Package: types and constants of the segment fit allocator.
package sfa_pkg;

   localparam int MAP_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAP_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int SCAN_W      = (CNT_W > 7) ? CNT_W : 7;

   localparam logic [16:0] MEM_SIZE_RESET = 17'd1024;
   localparam logic [16:0] MEM_SIZE_MAX   = 17'd65536;

   localparam logic [2:0] OP_BEST    = 3'd0;
   localparam logic [2:0] OP_FIRST   = 3'd1;
   localparam logic [2:0] OP_WORST   = 3'd2;
   localparam logic [2:0] OP_NEXT    = 3'd3;
   localparam logic [2:0] OP_RELEASE = 3'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [16:0] alloc_words;
      logic [15:0] owner_id;
      logic [5:0]  scan_start;
   } req_type;

   typedef struct packed {
      logic [15:0] block_start;
      logic [15:0] block_end;
      logic [16:0] block_size;
      logic [15:0] block_owner;
      logic        success;
      logic [6:0]  segment_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] seg_start;
      logic [15:0] seg_end;
      logic [15:0] seg_owner;
   } seg_entry_type;

endpackage

FILE: rtl/segment_fit_allocator_unit.sv
// Top level: contiguous segment allocator with best, first, worst and next fit, and release.
//
//   channel | dir | handshake           | content
//   req     | in  | req_valid/req_stall | opcode, size, owner, next-fit start
//   rsp     | out | rsp_valid/rsp_stall | block fields, success, segment count
//   csr     | in  | csr_valid/csr_ready | memory_size write data
//
// A request reads and checks each table entry scanned, then reads and writes
// each entry moved for a split or merge, all through the single read port of
// the segment table.
// Reset and every memory_size write rebuild entry 0 in state ST_INIT.
// req_stall is high from acceptance until the response is loaded; the result
// waits in the response register while rsp_stall holds it.
module segment_fit_allocator_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sfa_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sfa_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [16:0]      csr_data
);
   import sfa_pkg::*;

   typedef enum logic [18:0] {
      ST_INIT    = 19'b0000000000000000001,
      ST_IDLE    = 19'b0000000000000000010,
      ST_SCAN_RD = 19'b0000000000000000100,
      ST_SCAN_CK = 19'b0000000000000001000,
      ST_DECIDE  = 19'b0000000000000010000,
      ST_SHIFT_RD= 19'b0000000000000100000,
      ST_SHIFT_WR= 19'b0000000000001000000,
      ST_SPLIT_HI= 19'b0000000000010000000,
      ST_SPLIT_LO= 19'b0000000000100000000,
      ST_REL_RD  = 19'b0000000001000000000,
      ST_REL_CK  = 19'b0000000010000000000,
      ST_PREV_RD = 19'b0000000100000000000,
      ST_PREV_CK = 19'b0000001000000000000,
      ST_NEXT_RD = 19'b0000010000000000000,
      ST_NEXT_CK = 19'b0000100000000000000,
      ST_MERGE   = 19'b0001000000000000000,
      ST_DROP_RD = 19'b0010000000000000000,
      ST_DROP_WR = 19'b0100000000000000000,
      ST_DONE    = 19'b1000000000000000000
   } state_type;

   state_type     state_ff, state_in;
   logic [16:0]   mem_size_ff, mem_size_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SCAN_W-1:0] idx_ff, idx_in;
   req_type       op_ff, op_in;
   logic          found_ff, found_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic [16:0]   pick_ex_ff, pick_ex_in;
   seg_entry_type cur_ff, cur_in;
   logic [15:0]   prev_start_ff, prev_start_in;
   logic [15:0]   next_end_ff, next_end_in;
   logic          prev_free_ff, prev_free_in;
   logic          next_free_ff, next_free_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   seg_entry_type seg_mem [MAP_ENTRIES];
   seg_entry_type mem_rdata_ff;
   seg_entry_type mem_wdata;
   logic          mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;

   logic [16:0]   rd_size, rd_ex, clamp_size;
   logic          rd_fits, better;
   logic [SCAN_W-1:0] count_ext, drop_cnt, pick_ext, k_ext;
   logic [IDX_W-1:0] base_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seg_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= seg_mem[mem_raddr];
   end

   always_comb begin
      if (csr_data == 17'd0) begin
         clamp_size = 17'd1;
      end else if (csr_data > MEM_SIZE_MAX) begin
         clamp_size = MEM_SIZE_MAX;
      end else begin
         clamp_size = csr_data;
      end
   end

   assign rd_size   = {1'b0, mem_rdata_ff.seg_end} - {1'b0, mem_rdata_ff.seg_start} + 17'd1;
   assign rd_ex     = rd_size - op_ff.alloc_words;
   assign rd_fits   = (mem_rdata_ff.seg_owner == 16'd0) && (rd_size >= op_ff.alloc_words);
   assign better    = !found_ff || ((op_ff.opcode == OP_BEST) && (rd_ex < pick_ex_ff)) ||
                      ((op_ff.opcode == OP_WORST) && (rd_ex > pick_ex_ff));
   assign count_ext = SCAN_W'(count_ff);
   assign pick_ext  = SCAN_W'(pick_ff);
   assign drop_cnt  = SCAN_W'(prev_free_ff) + SCAN_W'(next_free_ff);
   assign base_idx  = prev_free_ff ? (pick_ff - IDX_W'(1)) : pick_ff;
   assign k_ext     = SCAN_W'(base_idx);

   always_comb begin
      state_in      = state_ff;
      mem_size_in   = mem_size_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      pick_ex_in    = pick_ex_ff;
      cur_in        = cur_ff;
      prev_start_in = prev_start_ff;
      next_end_in   = next_end_ff;
      prev_free_in  = prev_free_ff;
      next_free_in  = next_free_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[IDX_W-1:0];
      mem_wdata     = mem_rdata_ff;
      mem_raddr     = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{seg_start: 16'd0, seg_end: mem_size_ff[15:0] - 16'd1,
                          seg_owner: 16'd0};
            count_in  = CNT_W'(1);
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_valid) begin
               mem_size_in = clamp_size;
               state_in    = ST_INIT;
            end else if (req_valid) begin
               op_in    = req_payload;
               res_in   = '0;
               found_in = 1'b0;
               idx_in   = '0;
               if ((req_payload.opcode <= OP_NEXT) && (req_payload.alloc_words != 17'd0) &&
                   (req_payload.owner_id != 16'd0)) begin
                  if (req_payload.opcode == OP_NEXT) begin
                     idx_in = SCAN_W'(req_payload.scan_start);
                  end
                  state_in = ST_SCAN_RD;
               end else if ((req_payload.opcode == OP_RELEASE) &&
                            (req_payload.owner_id != 16'd0)) begin
                  state_in = ST_REL_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = (idx_ff < count_ext) ? ST_SCAN_CK : ST_DECIDE;
         end
         ST_SCAN_CK: begin
            idx_in   = idx_ff + SCAN_W'(1);
            state_in = ST_SCAN_RD;
            if (rd_fits && better) begin
               found_in   = 1'b1;
               pick_in    = idx_ff[IDX_W-1:0];
               pick_ex_in = rd_ex;
               cur_in     = mem_rdata_ff;
               if ((op_ff.opcode == OP_FIRST) || (op_ff.opcode == OP_NEXT)) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (!found_ff || ((pick_ex_ff != 17'd0) && (count_ext >= SCAN_W'(MAP_ENTRIES)))) begin
               state_in = ST_DONE;
            end else if (pick_ex_ff == 17'd0) begin
               mem_we    = 1'b1;
               mem_waddr = pick_ff;
               mem_wdata = '{seg_start: cur_ff.seg_start, seg_end: cur_ff.seg_end,
                             seg_owner: op_ff.owner_id};
               res_in.block_start = cur_ff.seg_start;
               res_in.block_end   = cur_ff.seg_end;
               res_in.block_size  = op_ff.alloc_words;
               res_in.block_owner = op_ff.owner_id;
               res_in.success     = 1'b1;
               state_in = ST_DONE;
            end else begin
               idx_in   = count_ext;
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            mem_raddr = idx_ff[IDX_W-1:0] - IDX_W'(1);
            state_in  = (idx_ff > pick_ext + SCAN_W'(1)) ? ST_SHIFT_WR : ST_SPLIT_HI;
         end
         ST_SHIFT_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_ff - SCAN_W'(1);
            state_in = ST_SHIFT_RD;
         end
         ST_SPLIT_HI: begin
            mem_we    = 1'b1;
            mem_waddr = pick_ff + IDX_W'(1);
            mem_wdata = '{seg_start: cur_ff.seg_start + op_ff.alloc_words[15:0],
                          seg_end: cur_ff.seg_end, seg_owner: 16'd0};
            state_in  = ST_SPLIT_LO;
         end
         ST_SPLIT_LO: begin
            mem_we    = 1'b1;
            mem_waddr = pick_ff;
            mem_wdata = '{seg_start: cur_ff.seg_start,
                          seg_end: cur_ff.seg_start + op_ff.alloc_words[15:0] - 16'd1,
                          seg_owner: op_ff.owner_id};
            count_in  = count_ff + CNT_W'(1);
            res_in.block_start = cur_ff.seg_start;
            res_in.block_end   = cur_ff.seg_start + op_ff.alloc_words[15:0] - 16'd1;
            res_in.block_size  = op_ff.alloc_words;
            res_in.block_owner = op_ff.owner_id;
            res_in.success     = 1'b1;
            state_in = ST_DONE;
         end
         ST_REL_RD: begin
            state_in = (idx_ff < count_ext) ? ST_REL_CK : ST_DONE;
         end
         ST_REL_CK: begin
            if (mem_rdata_ff.seg_owner == op_ff.owner_id) begin
               pick_in  = idx_ff[IDX_W-1:0];
               cur_in   = mem_rdata_ff;
               state_in = ST_PREV_RD;
            end else begin
               idx_in   = idx_ff + SCAN_W'(1);
               state_in = ST_REL_RD;
            end
         end
         ST_PREV_RD: begin
            mem_raddr    = pick_ff - IDX_W'(1);
            prev_free_in = 1'b0;
            state_in     = (pick_ff != '0) ? ST_PREV_CK : ST_NEXT_RD;
         end
         ST_PREV_CK: begin
            prev_free_in  = (mem_rdata_ff.seg_owner == 16'd0);
            prev_start_in = mem_rdata_ff.seg_start;
            state_in      = ST_NEXT_RD;
         end
         ST_NEXT_RD: begin
            mem_raddr    = pick_ff + IDX_W'(1);
            next_free_in = 1'b0;
            state_in     = (pick_ext + SCAN_W'(1) < count_ext) ? ST_NEXT_CK : ST_MERGE;
         end
         ST_NEXT_CK: begin
            next_free_in = (mem_rdata_ff.seg_owner == 16'd0);
            next_end_in  = mem_rdata_ff.seg_end;
            state_in     = ST_MERGE;
         end
         ST_MERGE: begin
            mem_we    = 1'b1;
            mem_waddr = base_idx;
            mem_wdata = '{seg_start: prev_free_ff ? prev_start_ff : cur_ff.seg_start,
                          seg_end: next_free_ff ? next_end_ff : cur_ff.seg_end,
                          seg_owner: 16'd0};
            res_in.success = 1'b1;
            idx_in   = k_ext + SCAN_W'(1);
            state_in = ST_DROP_RD;
         end
         ST_DROP_RD: begin
            mem_raddr = idx_ff[IDX_W-1:0] + drop_cnt[IDX_W-1:0];
            if ((drop_cnt != '0) && (idx_ff + drop_cnt < count_ext)) begin
               state_in = ST_DROP_WR;
            end else begin
               count_in = count_ff - CNT_W'(drop_cnt);
               state_in = ST_DONE;
            end
         end
         ST_DROP_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_ff + SCAN_W'(1);
            state_in = ST_DROP_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in               = res_ff;
               rsp_in.segment_count = 7'(count_ff);
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         mem_size_ff  <= MEM_SIZE_RESET;
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mem_size_ff  <= mem_size_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      pick_ex_ff    <= pick_ex_in;
      cur_ff        <= cur_in;
      prev_start_ff <= prev_start_in;
      next_end_ff   <= next_end_in;
      prev_free_ff  <= prev_free_in;
      next_free_ff  <= next_free_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/sfa_checker.sv
// Checker: port-level properties of the segment fit allocator, bound to the top level.
`include "assert_macros.svh"

module sfa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sfa_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sfa_pkg::rsp_type rsp_payload,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [16:0]      csr_data
);
   import sfa_pkg::*;

   `SFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `SFA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall && !csr_ready)
   `SFA_ASSERT_SAME(a_fail_zero, rsp_valid && !rsp_payload.success, rsp_payload.block_size == 17'd0 && rsp_payload.block_owner == 16'd0)
   `SFA_ASSERT_SAME(a_count_nonzero, rsp_valid, rsp_payload.segment_count != 7'd0)

endmodule

bind segment_fit_allocator_unit sfa_checker u_sfa_checker (.*);
